// File: rtl/pipelined_fetch_stage_macros.svh
// Assertion macros for the fetch stage.
// Used by pipelined_fetch_stage.sv; expects clk and rst in scope.
`ifndef PIPELINED_FETCH_STAGE_MACROS_SVH
`define PIPELINED_FETCH_STAGE_MACROS_SVH

// same-cycle implication
`define PFS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fetch stage assertion failed");

// next-cycle implication
`define PFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fetch stage assertion failed");

`endif

// File: rtl/pfs_pkg.sv
// Shared types, opcodes and helpers for the fetch stage.
// No dependencies.
package pfs_pkg;

  localparam int ADDR_W      = 64;
  localparam int CONST_BYTES = 8;
  localparam int CONST_W     = 8 * CONST_BYTES;

  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_NOP   = 4'h1;
  localparam logic [3:0] OP_RRMOV = 4'h2;
  localparam logic [3:0] OP_IRMOV = 4'h3;
  localparam logic [3:0] OP_RMMOV = 4'h4;
  localparam logic [3:0] OP_MRMOV = 4'h5;
  localparam logic [3:0] OP_ALU   = 4'h6;
  localparam logic [3:0] OP_JUMP  = 4'h7;
  localparam logic [3:0] OP_CALL  = 4'h8;
  localparam logic [3:0] OP_RET   = 4'h9;
  localparam logic [3:0] OP_PUSH  = 4'hA;
  localparam logic [3:0] OP_POP   = 4'hB;
  localparam logic [3:0] NO_REG   = 4'hF;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_INS  = 2'd3;

  typedef struct packed {
    logic [63:0]       instr_lo;
    logic [15:0]       instr_hi;
    logic              mem_error;
    logic [3:0]        m_icode;
    logic              m_cnd;
    logic [ADDR_W-1:0] m_val_a;
    logic [3:0]        w_icode;
    logic [ADDR_W-1:0] w_val_m;
    logic [3:0]        e_icode;
    logic [3:0]        e_dst_m;
    logic [7:0]        decode_sources;
    logic [3:0]        d_icode;
  } pfs_in_t;

  typedef struct packed {
    logic [3:0]         icode;
    logic [3:0]         ifun;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  val_p;
    logic [3:0]         reg_a;
    logic [3:0]         reg_b;
    logic [CONST_W-1:0] val_c;
    logic               fetch_stall;
    logic [ADDR_W-1:0]  fetch_pc;
  } pfs_out_t;

  typedef struct packed {
    logic              stall;
    logic [ADDR_W-1:0] pred;
  } pfs_ctl_t;

  function automatic logic has_regs(input logic [3:0] op);
    has_regs = op inside {OP_RRMOV, OP_ALU, OP_PUSH, OP_POP, OP_IRMOV, OP_RMMOV, OP_MRMOV};
  endfunction

  function automatic logic has_const(input logic [3:0] op);
    has_const = op inside {OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_JUMP, OP_CALL};
  endfunction

endpackage

// File: rtl/pfs_decode.sv
// Combinational fetch logic: PC select, instruction split, next PC, prediction, stall.
// Depends on pfs_pkg.
module pfs_decode (
  input  pfs_pkg::pfs_in_t                 fin,
  input  logic [pfs_pkg::ADDR_W-1:0]       predicted_pc,
  input  logic [pfs_pkg::CONST_W-1:0]      last_constant,
  output pfs_pkg::pfs_out_t                res,
  output pfs_pkg::pfs_ctl_t                ctl
);

  logic [79:0]                 bytes;
  logic [pfs_pkg::ADDR_W-1:0]  pc;
  logic [3:0]                  op;
  logic [3:0]                  fn;
  logic [1:0]                  st;
  logic [3:0]                  ra;
  logic [3:0]                  rb;
  logic [3:0]                  pos;
  logic [pfs_pkg::CONST_W-1:0] cval;
  logic [pfs_pkg::ADDR_W-1:0]  val_p;
  logic [3:0]                  src_a;
  logic [3:0]                  src_b;
  logic                        load_use;
  logic                        ret_busy;

  assign bytes = {fin.instr_hi, fin.instr_lo};
  assign src_a = fin.decode_sources[3:0];
  assign src_b = fin.decode_sources[7:4];

  always_comb begin
    // mispredicted branch wins over a returning ret
    if (fin.m_icode == pfs_pkg::OP_JUMP && !fin.m_cnd) begin
      pc = fin.m_val_a;
    end else if (fin.w_icode == pfs_pkg::OP_RET) begin
      pc = fin.w_val_m;
    end else begin
      pc = predicted_pc;
    end

    if (fin.mem_error) begin
      op = pfs_pkg::OP_NOP;
      fn = 4'h0;
      st = pfs_pkg::ST_ADDR;
    end else begin
      op = bytes[7:4];
      fn = bytes[3:0];
      if (op > pfs_pkg::OP_POP) begin
        st = pfs_pkg::ST_INS;
      end else if (op == pfs_pkg::OP_HALT) begin
        st = pfs_pkg::ST_HALT;
      end else begin
        st = pfs_pkg::ST_OK;
      end
    end

    ra  = pfs_pkg::NO_REG;
    rb  = pfs_pkg::NO_REG;
    pos = 4'd1;
    if (pfs_pkg::has_regs(op)) begin
      ra  = bytes[15:12];
      rb  = bytes[11:8];
      pos = 4'd2;
    end

    cval = last_constant;
    if (pfs_pkg::has_const(op)) begin
      // constant starts right after the register byte, if any
      cval = pfs_pkg::has_regs(op) ? bytes[79:16] : bytes[71:8];
      pos  = pos + 4'(pfs_pkg::CONST_BYTES);
    end

    val_p = pc + {{(pfs_pkg::ADDR_W-4){1'b0}}, pos};
  end

  assign load_use = (fin.e_icode == pfs_pkg::OP_MRMOV || fin.e_icode == pfs_pkg::OP_POP) &&
                    (fin.e_dst_m == src_a || fin.e_dst_m == src_b);
  assign ret_busy = fin.d_icode == pfs_pkg::OP_RET || fin.e_icode == pfs_pkg::OP_RET ||
                    fin.m_icode == pfs_pkg::OP_RET;

  assign ctl.stall = load_use || ret_busy;
  assign ctl.pred  = (op == pfs_pkg::OP_JUMP || op == pfs_pkg::OP_CALL) ? cval : val_p;

  assign res.icode       = op;
  assign res.ifun        = fn;
  assign res.status      = st;
  assign res.val_p       = val_p;
  assign res.reg_a       = ra;
  assign res.reg_b       = rb;
  assign res.val_c       = cval;
  assign res.fetch_stall = ctl.stall;
  assign res.fetch_pc    = pc;

endmodule

// File: rtl/pfs_state.sv
// Predicted PC and last-constant registers of the fetch stage.
// Depends on pfs_pkg.
module pfs_state (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  pfs_pkg::pfs_ctl_t           ctl,
  input  logic [pfs_pkg::CONST_W-1:0] constant,
  output logic [pfs_pkg::ADDR_W-1:0]  predicted_pc,
  output logic [pfs_pkg::CONST_W-1:0] last_constant
);

  always_ff @(posedge clk) begin
    if (rst) begin
      predicted_pc  <= '0;
      last_constant <= '0;
    end else if (advance) begin
      // constant already falls back to the held value when absent
      last_constant <= constant;
      if (!ctl.stall) begin
        predicted_pc <= ctl.pred;
      end
    end
  end

endmodule

// File: rtl/pipelined_fetch_stage.sv
// Fetch stage: one word accepted per cycle while the result register is free or draining;
// a word passes input register -> fetch logic -> result register, and out_ready back-pressure
// can hold it in either register. The predicted PC update feeds the very next word.
// Reset clears both valid flags, the predicted PC and the held constant to zero.
// Depends on pfs_pkg, pfs_decode, pfs_state and pipelined_fetch_stage_macros.svh.
`include "pipelined_fetch_stage_macros.svh"
module pipelined_fetch_stage (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] instr_lo,
  input  logic [15:0] instr_hi,
  input  logic        mem_error,
  input  logic [3:0]  m_icode,
  input  logic        m_cnd,
  input  logic [63:0] m_val_a,
  input  logic [3:0]  w_icode,
  input  logic [63:0] w_val_m,
  input  logic [3:0]  e_icode,
  input  logic [3:0]  e_dst_m,
  input  logic [7:0]  decode_sources,
  input  logic [3:0]  d_icode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  icode,
  output logic [3:0]  ifun,
  output logic [1:0]  status,
  output logic [63:0] val_p,
  output logic [3:0]  reg_a,
  output logic [3:0]  reg_b,
  output logic [63:0] val_c,
  output logic        fetch_stall,
  output logic [63:0] fetch_pc
);

  pfs_pkg::pfs_in_t                fetch_in;
  logic                            fetch_in_valid;
  pfs_pkg::pfs_out_t               fetch_out;
  pfs_pkg::pfs_out_t               res;
  pfs_pkg::pfs_ctl_t               ctl;
  logic [pfs_pkg::ADDR_W-1:0]      predicted_pc;
  logic [pfs_pkg::CONST_W-1:0]     last_constant;
  logic                            advance;

  // held word moves to the result register when that register is free or draining
  assign advance  = fetch_in_valid && (!out_valid || out_ready);
  assign in_ready = !fetch_in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_in_valid <= 1'b0;
    end else if (in_ready) begin
      fetch_in_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fetch_in.instr_lo       <= instr_lo;
      fetch_in.instr_hi       <= instr_hi;
      fetch_in.mem_error      <= mem_error;
      fetch_in.m_icode        <= m_icode;
      fetch_in.m_cnd          <= m_cnd;
      fetch_in.m_val_a        <= m_val_a;
      fetch_in.w_icode        <= w_icode;
      fetch_in.w_val_m        <= w_val_m;
      fetch_in.e_icode        <= e_icode;
      fetch_in.e_dst_m        <= e_dst_m;
      fetch_in.decode_sources <= decode_sources;
      fetch_in.d_icode        <= d_icode;
    end
  end

  pfs_decode u_decode (
    .fin           (fetch_in),
    .predicted_pc  (predicted_pc),
    .last_constant (last_constant),
    .res           (res),
    .ctl           (ctl)
  );

  pfs_state u_state (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .ctl           (ctl),
    .constant      (res.val_c),
    .predicted_pc  (predicted_pc),
    .last_constant (last_constant)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fetch_out <= res;
    end
  end

  assign icode       = fetch_out.icode;
  assign ifun        = fetch_out.ifun;
  assign status      = fetch_out.status;
  assign val_p       = fetch_out.val_p;
  assign reg_a       = fetch_out.reg_a;
  assign reg_b       = fetch_out.reg_b;
  assign val_c       = fetch_out.val_c;
  assign fetch_stall = fetch_out.fetch_stall;
  assign fetch_pc    = fetch_out.fetch_pc;

  `PFS_ASSERT_NEXT(a_stall_holds_pc, advance && ctl.stall, $stable(predicted_pc))
  `PFS_ASSERT_NEXT(a_advance_fills_out, advance, out_valid)
  `PFS_ASSERT_IMPL(a_empty_takes_word, !fetch_in_valid, in_ready)
  `PFS_ASSERT_IMPL(a_addr_err_is_nop, out_valid && status == pfs_pkg::ST_ADDR,
                   icode == pfs_pkg::OP_NOP && reg_a == pfs_pkg::NO_REG)

endmodule

// File: tb/sv/tb_pipelined_fetch_stage.sv
// Self-checking testbench for pipelined_fetch_stage: queue-fed driver, clocked monitor,
// and a fetch predictor that tracks the predicted PC and the held constant.
// Depends on pfs_pkg and the pipelined_fetch_stage RTL.
`timescale 1ns / 1ps
module tb_pipelined_fetch_stage;
  import pfs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready, out_valid;
  pfs_in_t     cur_word = '0;
  logic [3:0]  icode, ifun, reg_a, reg_b;
  logic [1:0]  status;
  logic [63:0] val_p, val_c, fetch_pc;
  logic        fetch_stall;

  pfs_in_t     pend_words[$];
  pfs_out_t    fetch_expect[$];
  logic [63:0] pred_pc = '0;
  logic [63:0] held_const = '0;
  bit          word_took = 0;
  int          idle_pct = 0;
  int          rx_hold_req = 0;
  int          words_queued = 0, words_in = 0, words_checked = 0;
  int          n_errors = 0, n_stall = 0, n_redirect = 0, n_merr = 0;

  pipelined_fetch_stage i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .instr_lo(cur_word.instr_lo), .instr_hi(cur_word.instr_hi),
    .mem_error(cur_word.mem_error), .m_icode(cur_word.m_icode), .m_cnd(cur_word.m_cnd),
    .m_val_a(cur_word.m_val_a), .w_icode(cur_word.w_icode), .w_val_m(cur_word.w_val_m),
    .e_icode(cur_word.e_icode), .e_dst_m(cur_word.e_dst_m),
    .decode_sources(cur_word.decode_sources), .d_icode(cur_word.d_icode),
    .out_valid(out_valid), .out_ready(out_ready),
    .icode(icode), .ifun(ifun), .status(status), .val_p(val_p),
    .reg_a(reg_a), .reg_b(reg_b), .val_c(val_c),
    .fetch_stall(fetch_stall), .fetch_pc(fetch_pc)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fetch model: PC select, field split, status, next PC and prediction update.
  task automatic fetch_predict(input pfs_in_t w, output pfs_out_t r);
    logic [79:0] bytes;
    logic [63:0] pc, next_pc;
    logic [3:0]  op, src_a, src_b;
    int          len;
    bit          regs, konst, stall;
    bytes = {w.instr_hi, w.instr_lo};
    if (w.m_icode == OP_JUMP && !w.m_cnd) begin
      pc = w.m_val_a;
      n_redirect++;
    end else if (w.w_icode == OP_RET) begin
      pc = w.w_val_m;
      n_redirect++;
    end else begin
      pc = pred_pc;
    end
    r = '0;
    if (w.mem_error) begin
      op = OP_NOP;
      r.ifun = 4'h0;
      r.status = ST_ADDR;
      n_merr++;
    end else begin
      op = bytes[7:4];
      r.ifun = bytes[3:0];
      if (op > OP_POP) r.status = ST_INS;
      else if (op == OP_HALT) r.status = ST_HALT;
      else r.status = ST_OK;
    end
    case (op)
      OP_RRMOV, OP_ALU, OP_PUSH, OP_POP: begin regs = 1; konst = 0; end
      OP_IRMOV, OP_RMMOV, OP_MRMOV:      begin regs = 1; konst = 1; end
      OP_JUMP, OP_CALL:                  begin regs = 0; konst = 1; end
      default:                           begin regs = 0; konst = 0; end
    endcase
    len = 1;
    r.reg_a = NO_REG;
    r.reg_b = NO_REG;
    if (regs) begin
      r.reg_a = bytes[15:12];
      r.reg_b = bytes[11:8];
      len = 2;
    end
    if (konst) begin
      held_const = bytes[8*len +: 64];
      len += 8;
    end
    next_pc = pc + 64'(len);
    src_a = w.decode_sources[3:0];
    src_b = w.decode_sources[7:4];
    stall = ((w.e_icode == OP_MRMOV || w.e_icode == OP_POP) &&
             (w.e_dst_m == src_a || w.e_dst_m == src_b)) ||
            w.d_icode == OP_RET || w.e_icode == OP_RET || w.m_icode == OP_RET;
    if (stall) n_stall++;
    else pred_pc = (op == OP_JUMP || op == OP_CALL) ? held_const : next_pc;
    r.icode = op;
    r.val_p = next_pc;
    r.val_c = held_const;
    r.fetch_stall = stall;
    r.fetch_pc = pc;
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t: result %0d field %s got %h want %h", $time, words_checked, field,
               got, want);
  endtask

  // Monitor: check the result first, then predict the word taken at this edge.
  always @(posedge clk) begin
    pfs_out_t want, got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{icode, ifun, status, val_p, reg_a, reg_b, val_c, fetch_stall, fetch_pc};
        if (fetch_expect.size() == 0) begin
          flag_mismatch("unexpected", '0, '0);
        end else begin
          want = fetch_expect.pop_front();
          if (got.icode !== want.icode)
            flag_mismatch("icode", 64'(got.icode), 64'(want.icode));
          if (got.ifun !== want.ifun)
            flag_mismatch("ifun", 64'(got.ifun), 64'(want.ifun));
          if (got.status !== want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.val_p !== want.val_p) flag_mismatch("val_p", got.val_p, want.val_p);
          if (got.reg_a !== want.reg_a)
            flag_mismatch("reg_a", 64'(got.reg_a), 64'(want.reg_a));
          if (got.reg_b !== want.reg_b)
            flag_mismatch("reg_b", 64'(got.reg_b), 64'(want.reg_b));
          if (got.val_c !== want.val_c) flag_mismatch("val_c", got.val_c, want.val_c);
          if (got.fetch_stall !== want.fetch_stall)
            flag_mismatch("fetch_stall", 64'(got.fetch_stall), 64'(want.fetch_stall));
          if (got.fetch_pc !== want.fetch_pc)
            flag_mismatch("fetch_pc", got.fetch_pc, want.fetch_pc);
        end
        words_checked++;
      end
      word_took = in_valid && in_ready;
      if (word_took) begin
        fetch_predict(cur_word, want);
        fetch_expect.push_back(want);
        words_in++;
      end
    end
  end

  // Driver: valid holds until the word is taken; gaps only between words.
  always @(negedge clk) begin
    int tx_gap;
    if (!rst && (!in_valid || word_took)) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        tx_gap = $urandom_range(0, 18);
      end else if (pend_words.size() > 0) begin
        in_valid <= 1'b1;
        cur_word <= pend_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus a long hold-off on request.
  always @(negedge clk) begin
    int rx_gap, hold_left;
    if (!rst) begin
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        rx_gap = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic pfs_in_t calm_word(input logic [3:0] op);
    pfs_in_t w;
    w.instr_lo = rand64();
    w.instr_hi = 16'($urandom);
    w.instr_lo[7:4] = op;
    w.mem_error = 1'b0;
    w.m_icode = OP_NOP;
    w.m_cnd = 1'($urandom);
    w.m_val_a = rand64();
    w.w_icode = OP_NOP;
    w.w_val_m = rand64();
    w.e_icode = OP_NOP;
    w.e_dst_m = NO_REG;
    w.decode_sources = 8'($urandom);
    w.d_icode = OP_NOP;
    return w;
  endfunction

  // Mostly valid opcodes and plausible hazard traffic, with some junk mixed in.
  function automatic pfs_in_t random_word();
    pfs_in_t w;
    int      pick;
    w = calm_word($urandom_range(0, 99) < 88 ? 4'($urandom_range(0, 11)) : 4'($urandom));
    w.mem_error = ($urandom_range(0, 15) == 0);
    pick = $urandom_range(0, 99);
    w.m_icode = pick < 20 ? OP_JUMP : pick < 26 ? OP_RET : pick < 60 ? OP_NOP : 4'($urandom);
    if ($urandom_range(0, 7) == 0) w.m_val_a = '1 - 64'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    w.w_icode = pick < 12 ? OP_RET : pick < 60 ? OP_NOP : 4'($urandom);
    if ($urandom_range(0, 7) == 0) w.w_val_m = '1 - 64'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    w.e_icode = pick < 15 ? OP_MRMOV : pick < 25 ? OP_POP : pick < 29 ? OP_RET :
                pick < 65 ? OP_NOP : 4'($urandom);
    w.e_dst_m = 4'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2) w.decode_sources[3:0] = w.e_dst_m;
    else if (pick < 4) w.decode_sources[7:4] = w.e_dst_m;
    pick = $urandom_range(0, 99);
    w.d_icode = pick < 5 ? OP_RET : pick < 60 ? OP_NOP : 4'($urandom);
    return w;
  endfunction

  task automatic queue_word(input pfs_in_t w);
    pend_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_in != words_queued || fetch_expect.size() != 0) @(posedge clk);
  endtask

  initial begin
    #3_000_000;
    $display("pipelined_fetch_stage: mismatch");
    $finish;
  end

  initial begin
    pfs_in_t w;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: every opcode with no hazards; halt on all-zero bytes, invalid on all-ones.
    for (int op = 0; op < 16; op++) begin
      w = calm_word(4'(op));
      if (op == 0) {w.instr_hi, w.instr_lo} = '0;
      if (op == 15) {w.instr_hi, w.instr_lo} = '1;
      // call to the top address so the following ret wraps its next PC to zero
      if (4'(op) == OP_CALL) {w.instr_hi[7:0], w.instr_lo[63:8]} = '1;
      queue_word(w);
    end
    w = calm_word(OP_NOP);
    w.mem_error = 1'b1;
    {w.instr_hi, w.instr_lo} = '1;
    queue_word(w);
    w = calm_word(OP_IRMOV);           // mispredicted jump to the top address, wraps
    w.m_icode = OP_JUMP;
    w.m_cnd = 1'b0;
    w.m_val_a = '1;
    queue_word(w);
    w = calm_word(OP_JUMP);            // taken jump in memory, ret completing
    w.m_icode = OP_JUMP;
    w.m_cnd = 1'b1;
    w.w_icode = OP_RET;
    w.w_val_m = '1 - 64'd1;
    queue_word(w);
    w = calm_word(OP_ALU);             // load/use on register id 15
    w.e_icode = OP_MRMOV;
    w.e_dst_m = NO_REG;
    w.decode_sources = 8'hFF;
    queue_word(w);
    w = calm_word(OP_PUSH);            // pop result feeding src_b
    w.e_icode = OP_POP;
    w.e_dst_m = 4'd3;
    w.decode_sources = 8'h30;
    queue_word(w);
    w = calm_word(OP_NOP);
    w.d_icode = OP_RET;
    queue_word(w);
    w = calm_word(OP_NOP);
    w.e_icode = OP_RET;
    queue_word(w);
    w = calm_word(OP_RMMOV);
    w.m_icode = OP_RET;
    queue_word(w);
    w = calm_word(OP_CALL);            // memory error on a redirected fetch
    w.mem_error = 1'b1;
    w.m_icode = OP_JUMP;
    w.m_cnd = 1'b0;
    queue_word(w);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    rx_hold_req = 300;
    for (int i = 0; i < 60; i++) queue_word(random_word());
    wait_drained();

    for (int chunk = 0; chunk < 10; chunk++) begin
      idle_pct = chunk >= 8 ? 0 : (chunk % 3 == 1) ? 0 : (chunk % 3 == 0) ? 15 : 40;
      if (chunk == 5) wait_drained();
      for (int i = 0; i < 100; i++) queue_word(random_word());
      while (pend_words.size() != 0) @(posedge clk);
    end
    wait_drained();
    repeat (5) @(posedge clk);

    $display("fetched %0d words, checked %0d results: %0d stalled, %0d redirected,",
             words_in, words_checked, n_stall, n_redirect);
    $display("%0d with a memory error, %0d field mismatches", n_merr, n_errors);
    if (n_errors == 0 && fetch_expect.size() == 0)
      $display("pipelined_fetch_stage: match");
    else
      $display("pipelined_fetch_stage: mismatch");
    $finish;
  end
endmodule
